// ===== hw/rtl/differential_drive_odometry_core_macros.svh =====
// Assertion macros for the odometry checker
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH

// same-cycle implication
`define DDO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("odometry check failed");

// next-cycle implication
`define DDO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("odometry check failed");

`endif

// ===== hw/rtl/ddo_pkg.sv =====
// Shared types, constants and tables for the odometry core
`default_nettype none
package ddo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam int MULA_W = 50;
  localparam int MULB_W = 32;
  localparam int PROD_W = MULA_W + MULB_W;

  localparam logic [1:0] CMD_STEP       = 2'd0;
  localparam logic [1:0] CMD_RESET_POSE = 2'd1;
  localparam logic [1:0] CMD_RESET_PATH = 2'd2;
  localparam logic [1:0] CMD_NOP        = 2'd3;

  localparam logic [1:0] REG_DIST_PER_TICK = 2'd0;
  localparam logic [1:0] REG_INV_BASE      = 2'd1;
  localparam logic [1:0] REG_ANGLE_GAIN    = 2'd2;

  localparam logic signed [35:0] TWO_PI_Q30   = 36'sd6746518852;
  localparam logic signed [35:0] PI_Q30       = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30  = 36'sd1686629713;
  localparam logic signed [35:0] CORDIC_K_Q30 = 36'sd652032874;
  localparam logic [46:0]        TWO_PI_MOD   = 47'd6746518852;

  typedef struct packed {
    logic              start;
    logic [MULA_W-1:0] a;
    logic [MULB_W-1:0] b;
  } mul_req_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      5'd31: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ddo_if.sv =====
// Channel interfaces: tick request, pose result and register write
`default_nettype none
interface ddo_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [15:0] ticks_left;
  logic signed [15:0] ticks_right;
  modport source (output valid, command, ticks_left, ticks_right, input ready);
  modport sink   (input valid, command, ticks_left, ticks_right, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] x_mm;
  logic signed [47:0] y_mm;
  logic signed [39:0] heading_rad;
  logic signed [47:0] path_left;
  logic signed [47:0] path_right;
  logic               saturated;
  modport source (output valid, x_mm, y_mm, heading_rad, path_left, path_right, saturated,
                  input ready);
  modport sink   (input valid, x_mm, y_mm, heading_rad, path_left, path_right, saturated,
                  output ready);
endinterface

interface ddo_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ddo_mul.sv =====
// Shared shift-add multiplier, one multiplier bit per cycle
`default_nettype none
module ddo_mul import ddo_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  mul_req_t          req,
  output logic              busy,
  output logic [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] a_r, a_nxt, p_r, p_nxt;
  logic [MULB_W-1:0] b_r, b_nxt;
  logic              run_r, run_nxt;

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    p_nxt   = p_r;
    run_nxt = run_r;
    if (req.start) begin
      a_nxt   = PROD_W'(req.a);
      b_nxt   = req.b;
      p_nxt   = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      // stops as soon as no multiplier bits remain
      if (b_r == '0) begin
        run_nxt = 1'b0;
      end else begin
        if (b_r[0]) p_nxt = p_r + a_r;
        a_nxt = a_r << 1;
        b_nxt = b_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign busy = run_r;
  assign prod = p_r;

endmodule
`default_nettype wire

// ===== hw/rtl/differential_drive_odometry_core.sv =====
// Differential-drive wheel odometry core: top level and sequencer
`default_nettype none
// One request is taken at a time; in_ch.ready is low until its result has been
// taken. A tick step runs six products through one shift-add multiplier (one
// multiplier bit per cycle, stopping at the highest set bit, with a start state
// and a wait state per product), a 14-step restoring reduction of the heading
// modulo 2*pi, and CORDIC_STEPS rotations; most of the time from acceptance to
// the result is spent in the multiplier. Reset commands and the unused command
// go straight from idle to the result state. Registers may be written at any
// time through cfg_ch, which is always ready, but only take sensible effect
// while the core is idle. Distances are Q32.16 mm, heading Q16.24 rad (not
// wrapped); all accumulators saturate and flag it.
module differential_drive_odometry_core import ddo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ddo_in_if.sink    in_ch,
  ddo_out_if.source out_ch,
  ddo_cfg_if.sink   cfg_ch
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_ML   = 5'd1;
  localparam logic [4:0] S_WL   = 5'd2;
  localparam logic [4:0] S_MR   = 5'd3;
  localparam logic [4:0] S_WR   = 5'd4;
  localparam logic [4:0] S_ACC  = 5'd5;
  localparam logic [4:0] S_MD   = 5'd6;
  localparam logic [4:0] S_WD   = 5'd7;
  localparam logic [4:0] S_MG   = 5'd8;
  localparam logic [4:0] S_WG   = 5'd9;
  localparam logic [4:0] S_MODI = 5'd10;
  localparam logic [4:0] S_MOD  = 5'd11;
  localparam logic [4:0] S_FOLD = 5'd12;
  localparam logic [4:0] S_COR  = 5'd13;
  localparam logic [4:0] S_MX   = 5'd14;
  localparam logic [4:0] S_WX   = 5'd15;
  localparam logic [4:0] S_MY   = 5'd16;
  localparam logic [4:0] S_WY   = 5'd17;
  localparam logic [4:0] S_OUT  = 5'd18;

  logic [4:0]  state_r;
  logic [31:0] dpt_r, ibw_r;
  logic [17:0] gain_r;

  logic signed [15:0] tl_r, tr_r;
  logic signed [41:0] dl_r, dr_r;
  logic signed [47:0] pos_x_r, pos_y_r, dist_l_r, dist_r_r;
  logic signed [39:0] head_r;
  logic               sat_r;
  logic [42:0]        diff_mag_r, half_mag_r;
  logic               diff_neg_r, half_neg_r;
  logic [49:0]        t_r;
  logic [46:0]        mod_r;
  logic               mod_neg_r;
  logic [3:0]         j_r;
  logic signed [35:0] cx_r, cy_r, cz_r;
  logic               fold_r;
  logic [STEP_W-1:0]  it_r;

  mul_req_t          mreq;
  logic              mbusy;
  logic [PROD_W-1:0] prod;

  ddo_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .busy (mbusy),
    .prod (prod)
  );

  // tick magnitudes
  logic [16:0] tl_mag, tr_mag;
  assign tl_mag = ({17{tl_r[15]}} ^ {tl_r[15], tl_r}) + 17'(tl_r[15]);
  assign tr_mag = ({17{tr_r[15]}} ^ {tr_r[15], tr_r}) + 17'(tr_r[15]);

  // trig term for position products; cos and sin flip sign when folded
  logic               is_y, t_neg, xy_neg;
  logic signed [35:0] trig, tv;
  logic [35:0]        t_mag;
  assign is_y   = (state_r == S_MY) || (state_r == S_WY);
  assign trig   = is_y ? cy_r : cx_r;
  assign tv     = fold_r ? -trig : trig;
  assign t_neg  = tv[35];
  assign t_mag  = (tv ^ {36{t_neg}}) + 36'(t_neg);
  assign xy_neg = half_neg_r ^ t_neg;

  always_comb begin
    mreq = '0;
    unique case (state_r)
      S_ML: begin
        mreq.start = 1'b1;
        mreq.a = MULA_W'(dpt_r);
        mreq.b = MULB_W'(tl_mag);
      end
      S_MR: begin
        mreq.start = 1'b1;
        mreq.a = MULA_W'(dpt_r);
        mreq.b = MULB_W'(tr_mag);
      end
      S_MD: begin
        mreq.start = 1'b1;
        mreq.a = MULA_W'(diff_mag_r);
        mreq.b = ibw_r;
      end
      S_MG: begin
        mreq.start = 1'b1;
        mreq.a = t_r;
        mreq.b = MULB_W'(gain_r);
      end
      S_MX, S_MY: begin
        mreq.start = 1'b1;
        mreq.a = MULA_W'(half_mag_r);
        mreq.b = t_mag[31:0];
      end
      default: mreq = '0;
    endcase
  end

  // wheel distance from the tick product, Q26.16
  logic               tick_neg;
  logic signed [41:0] tick_d;
  assign tick_neg = (state_r == S_WL) ? tl_r[15] : tr_r[15];
  assign tick_d   = tick_neg ? -$signed({1'b0, prod[48:8]}) : $signed({1'b0, prod[48:8]});

  // path totals, wheel difference and half sum
  logic signed [53:0] pl_sum, pr_sum;
  logic signed [42:0] dd, ss;
  logic [42:0]        dd_mag, ss_mag;
  assign pl_sum = 54'(dist_l_r) + 54'(dl_r);
  assign pr_sum = 54'(dist_r_r) + 54'(dr_r);
  assign dd     = 43'(dr_r) - 43'(dl_r);
  assign ss     = 43'(dl_r) + 43'(dr_r);
  assign dd_mag = (dd ^ {43{dd[42]}}) + 43'(dd[42]);
  assign ss_mag = (ss ^ {43{ss[42]}}) + 43'(ss[42]);

  // heading update
  logic signed [53:0] dth, h_sum;
  assign dth   = diff_neg_r ? -$signed({2'b00, prod[67:16]}) : $signed({2'b00, prod[67:16]});
  assign h_sum = 54'(head_r) + dth;

  logic [39:0] head_mag;
  assign head_mag = (head_r ^ {40{head_r[39]}}) + 40'(head_r[39]);

  // position update
  logic signed [53:0] dpos, px_sum, py_sum;
  assign dpos   = xy_neg ? -$signed({2'b00, prod[81:30]}) : $signed({2'b00, prod[81:30]});
  assign px_sum = 54'(pos_x_r) + dpos;
  assign py_sum = 54'(pos_y_r) + dpos;

  // reduction modulo 2*pi
  logic [46:0] tpj;
  assign tpj = TWO_PI_MOD << j_r;

  logic signed [35:0] r0, r1;
  assign r0 = mod_neg_r ? -$signed({1'b0, mod_r[34:0]}) : $signed({1'b0, mod_r[34:0]});
  always_comb begin
    priority if (r0 > PI_Q30) r1 = r0 - TWO_PI_Q30;
    else if (r0 < -PI_Q30)    r1 = r0 + TWO_PI_Q30;
    else                      r1 = r0;
  end

  // CORDIC rotation
  logic signed [35:0] xs, ys, at;
  assign xs = cx_r >>> it_r;
  assign ys = cy_r >>> it_r;
  assign at = $signed({4'b0000, atan_q30(5'(it_r))});

  function automatic logic ovf48(input logic signed [53:0] v);
    return !((&v[53:47]) || !(|v[53:47]));
  endfunction

  function automatic logic signed [47:0] clip48(input logic signed [53:0] v);
    if (ovf48(v)) return v[53] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    return v[47:0];
  endfunction

  logic h_ovf;
  assign h_ovf = !((&h_sum[53:39]) || !(|h_sum[53:39]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      dpt_r    <= '0;
      ibw_r    <= '0;
      gain_r   <= 18'd65536;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      head_r   <= '0;
      dist_l_r <= '0;
      dist_r_r <= '0;
      sat_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_DIST_PER_TICK: dpt_r  <= cfg_ch.data;
          REG_INV_BASE:      ibw_r  <= cfg_ch.data;
          REG_ANGLE_GAIN:    gain_r <= cfg_ch.data[17:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            sat_r <= 1'b0;
            tl_r  <= in_ch.ticks_left;
            tr_r  <= in_ch.ticks_right;
            unique case (in_ch.command)
              CMD_STEP: state_r <= S_ML;
              CMD_RESET_POSE: begin
                pos_x_r  <= '0;
                pos_y_r  <= '0;
                head_r   <= '0;
                dist_l_r <= '0;
                dist_r_r <= '0;
                state_r  <= S_OUT;
              end
              CMD_RESET_PATH: begin
                dist_l_r <= '0;
                dist_r_r <= '0;
                state_r  <= S_OUT;
              end
              CMD_NOP: state_r <= S_OUT;
            endcase
          end
        end
        S_ML: state_r <= S_WL;
        S_WL: begin
          if (!mbusy) begin
            dl_r    <= tick_d;
            state_r <= S_MR;
          end
        end
        S_MR: state_r <= S_WR;
        S_WR: begin
          if (!mbusy) begin
            dr_r    <= tick_d;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          dist_l_r   <= clip48(pl_sum);
          dist_r_r   <= clip48(pr_sum);
          sat_r      <= sat_r | ovf48(pl_sum) | ovf48(pr_sum);
          diff_mag_r <= dd_mag;
          diff_neg_r <= dd[42];
          half_mag_r <= ss_mag >> 1;
          half_neg_r <= ss[42];
          state_r    <= S_MD;
        end
        S_MD: state_r <= S_WD;
        S_WD: begin
          if (!mbusy) begin
            t_r     <= prod[73:24];
            state_r <= S_MG;
          end
        end
        S_MG: state_r <= S_WG;
        S_WG: begin
          if (!mbusy) begin
            if (h_ovf) head_r <= h_sum[53] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
            else       head_r <= h_sum[39:0];
            sat_r   <= sat_r | h_ovf;
            state_r <= S_MODI;
          end
        end
        S_MODI: begin
          mod_r     <= 47'({head_mag, 6'b000000});
          mod_neg_r <= head_r[39];
          j_r       <= 4'd13;
          state_r   <= S_MOD;
        end
        S_MOD: begin
          if (mod_r >= tpj) mod_r <= mod_r - tpj;
          if (j_r == 4'd0) state_r <= S_FOLD;
          else             j_r <= j_r - 4'd1;
        end
        S_FOLD: begin
          priority if (r1 > HALF_PI_Q30) begin
            cz_r   <= r1 - PI_Q30;
            fold_r <= 1'b1;
          end else if (r1 < -HALF_PI_Q30) begin
            cz_r   <= r1 + PI_Q30;
            fold_r <= 1'b1;
          end else begin
            cz_r   <= r1;
            fold_r <= 1'b0;
          end
          cx_r    <= CORDIC_K_Q30;
          cy_r    <= '0;
          it_r    <= '0;
          state_r <= S_COR;
        end
        S_COR: begin
          if (!cz_r[35]) begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            cz_r <= cz_r - at;
          end else begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            cz_r <= cz_r + at;
          end
          if (it_r == STEP_W'(CORDIC_STEPS - 1)) state_r <= S_MX;
          else                                   it_r <= it_r + STEP_W'(1);
        end
        S_MX: state_r <= S_WX;
        S_WX: begin
          if (!mbusy) begin
            pos_x_r <= clip48(px_sum);
            sat_r   <= sat_r | ovf48(px_sum);
            state_r <= S_MY;
          end
        end
        S_MY: state_r <= S_WY;
        S_WY: begin
          if (!mbusy) begin
            pos_y_r <= clip48(py_sum);
            sat_r   <= sat_r | ovf48(py_sum);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.x_mm        = pos_x_r;
  assign out_ch.y_mm        = pos_y_r;
  assign out_ch.heading_rad = head_r;
  assign out_ch.path_left   = dist_l_r;
  assign out_ch.path_right  = dist_r_r;
  assign out_ch.saturated   = sat_r;

endmodule
`default_nettype wire

// ===== hw/rtl/ddo_checker.sv =====
// Port-level checker for the odometry core, bound to the top level
`default_nettype none
`include "differential_drive_odometry_core_macros.svh"
module ddo_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // one request in flight: never ready while a result is shown
  `DDO_ASSERT_NOW(a_excl, clk, rst_n, in_ready, !out_valid)
  `DDO_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  `DDO_ASSERT_NEXT(a_back, clk, rst_n, out_valid && out_ready, in_ready && !out_valid)
  `DDO_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready)
);
`default_nettype wire
